// ----- rtl/core/bvtf_pkg.sv -----
// shared types and constants of the bitmap video timing and fetch core
package bvtf_pkg;

  // item operation codes
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // beam level codes
  localparam logic [1:0] LEVEL_PIXELS = 2'd0;
  localparam logic [1:0] LEVEL_BLANK  = 2'd1;
  localparam logic [1:0] LEVEL_SYNC   = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_RAM_WORD_MASK    = 2'd0;
  localparam logic [1:0] REG_ALTERNATE_SCREEN = 2'd1;
  localparam logic [1:0] REG_ALTERNATE_SOUND  = 2'd2;

  // frame layout in lines
  localparam logic [8:0] ACTIVE_LINES     = 9'd342;
  localparam logic [8:0] VSYNC_FIRST_LINE = 9'd353;
  localparam logic [8:0] VSYNC_END_LINE   = 9'd356;

  // buffer base word addresses, low 16 bits (the mask is 16 bits wide)
  localparam logic [15:0] SCREEN_MAIN_BASE = 16'hd380;
  localparam logic [15:0] SCREEN_ALT_BASE  = 16'h9380;
  localparam logic [15:0] SOUND_MAIN_BASE  = 16'hfe80;
  localparam logic [15:0] SOUND_ALT_BASE   = 16'hd080;

  // input item
  typedef struct packed {
    logic        operation;
    logic [15:0] write_address;
    logic [15:0] write_data;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [15:0] pixel_word;
    logic        pixel_valid;
    logic [1:0]  beam_level;
    logic        vertical_sync;
    logic [7:0]  sound_byte;
    logic [7:0]  drive_speed_byte;
    logic        sample_valid;
    logic [8:0]  line_number;
    logic [5:0]  slot_number;
  } out_item_t;

endpackage

// ----- rtl/core/bvtf_ram.sv -----
// generic single-clock ram, one write port and one registered read port
module bvtf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/core/bitmap_video_timing_fetch_core.sv -----
// top level: raster timing, frame and sound word fetch, ram load and config port
//
// Each tick item runs one 16-pixel word slot of a monochrome raster and yields one
// result item; a write item loads one word of the internal word ram and yields none.
// The block takes one item per cycle while in_stall is low. For a tick item the ram
// read of the frame or sound word is issued at the accepting edge, and the result
// register loads the read data when the fetch stage advances into it. The single
// registered read port of the word ram is why the fetch stage exists; a stall on the
// result side backs up into in_stall once both stages are full. The ram has no reset and needs
// no clearing pass; it must be written before any frame or sound word is fetched.
// Configuration goes through the APB port at byte addresses 0 (ram_word_mask),
// 4 (alternate_screen) and 8 (alternate_sound) and should only be written while no
// items are in flight.
module bitmap_video_timing_fetch_core
  import bvtf_pkg::*;
#(
  parameter int SLOTS_PER_LINE  = 44,
  parameter int PIXEL_SLOTS     = 32,
  parameter int SYNC_START_SLOT = 37,
  parameter int SYNC_END_SLOT   = 39,
  parameter int LINES_PER_FRAME = 370,
  parameter int RAM_WORDS       = 65536
) (
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  // result items
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = $clog2(RAM_WORDS);

  // configuration registers
  logic [15:0] ram_word_mask;
  logic        alternate_screen;
  logic        alternate_sound;

  // raster state
  logic [5:0]  slot_counter;
  logic [8:0]  line_counter;
  logic [13:0] screen_offset;
  logic [8:0]  sound_offset;

  // fetch stage
  logic        s1_valid;
  logic        s1_pixel_valid;
  logic [1:0]  s1_level;
  logic        s1_vsync;
  logic        s1_sample_valid;
  logic [8:0]  s1_line;
  logic [5:0]  s1_slot;
  logic        s1_advance;

  logic        take;
  logic        tick;
  logic        wr_en;
  logic        pix_slot;
  logic        last_slot;
  logic        last_line;
  logic        hsync_slot;
  logic        vsync_line;
  logic [1:0]  level;
  logic [15:0] screen_base;
  logic [15:0] sound_base;
  logic [AW-1:0] screen_addr;
  logic [AW-1:0] sound_addr;
  logic        rd_en;
  logic [AW-1:0] rd_addr;
  logic [15:0] rd_data;
  logic        cfg_write;

  // apb register access
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ram_word_mask    <= 16'hffff;
      alternate_screen <= 1'b0;
      alternate_sound  <= 1'b0;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_RAM_WORD_MASK:    ram_word_mask    <= pwdata[15:0];
        REG_ALTERNATE_SCREEN: alternate_screen <= pwdata[0];
        REG_ALTERNATE_SOUND:  alternate_sound  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_RAM_WORD_MASK:    prdata = {16'd0, ram_word_mask};
      REG_ALTERNATE_SCREEN: prdata = {31'd0, alternate_screen};
      REG_ALTERNATE_SOUND:  prdata = {31'd0, alternate_sound};
      default:              prdata = 32'd0;
    endcase
  end

  // handshake: hold input while the fetch stage cannot move on
  assign s1_advance = !out_valid || !out_stall;
  assign in_stall   = s1_valid && !s1_advance;
  assign take       = in_valid && !in_stall;
  assign tick       = take && (in_item.operation == OP_TICK);
  assign wr_en      = take && (in_item.operation == OP_WRITE);

  // slot classification
  assign last_slot  = slot_counter == 6'(SLOTS_PER_LINE - 1);
  assign last_line  = line_counter == 9'(LINES_PER_FRAME - 1);
  assign pix_slot   = (line_counter < ACTIVE_LINES) && (slot_counter < 6'(PIXEL_SLOTS));
  assign hsync_slot = (slot_counter >= 6'(SYNC_START_SLOT))
                   && (slot_counter < 6'(SYNC_END_SLOT));
  assign vsync_line = (line_counter >= VSYNC_FIRST_LINE) && (line_counter < VSYNC_END_LINE);

  always_comb begin
    if (pix_slot) begin
      level = LEVEL_PIXELS;
    end else if (line_counter >= ACTIVE_LINES && vsync_line) begin
      level = hsync_slot ? LEVEL_BLANK : LEVEL_SYNC;
    end else begin
      level = hsync_slot ? LEVEL_SYNC : LEVEL_BLANK;
    end
  end

  // fetch addresses wrap at the ram depth
  assign screen_base = (alternate_screen ? SCREEN_ALT_BASE : SCREEN_MAIN_BASE) & ram_word_mask;
  assign sound_base  = (alternate_sound ? SOUND_ALT_BASE : SOUND_MAIN_BASE) & ram_word_mask;
  assign screen_addr = AW'(screen_base) + AW'(screen_offset);
  assign sound_addr  = AW'(sound_base) + AW'(sound_offset);
  assign rd_en       = tick && (pix_slot || last_slot);
  assign rd_addr     = pix_slot ? screen_addr : sound_addr;

  bvtf_ram #(
    .WIDTH (16),
    .DEPTH (RAM_WORDS)
  ) u_word_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(in_item.write_address)),
    .wr_data (in_item.write_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // raster counters and offsets
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_counter  <= '0;
      line_counter  <= '0;
      screen_offset <= '0;
      sound_offset  <= '0;
    end else if (tick) begin
      if (last_slot) begin
        slot_counter <= '0;
        if (last_line) begin
          line_counter  <= '0;
          screen_offset <= '0;
          sound_offset  <= '0;
        end else begin
          line_counter <= line_counter + 9'd1;
          sound_offset <= sound_offset + 9'd1;
          if (pix_slot) begin
            screen_offset <= screen_offset + 14'd1;
          end
        end
      end else begin
        slot_counter <= slot_counter + 6'd1;
        if (pix_slot) begin
          screen_offset <= screen_offset + 14'd1;
        end
      end
    end
  end

  // fetch stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (tick) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  // fetch stage payload
  always_ff @(posedge clk) begin
    if (tick) begin
      s1_pixel_valid  <= pix_slot;
      s1_level        <= level;
      s1_vsync        <= vsync_line;
      s1_sample_valid <= last_slot;
      s1_line         <= line_counter;
      s1_slot         <= slot_counter;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_valid && s1_advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_advance) begin
      out_item.pixel_word       <= s1_pixel_valid ? ~rd_data : 16'd0;
      out_item.pixel_valid      <= s1_pixel_valid;
      out_item.beam_level       <= s1_level;
      out_item.vertical_sync    <= s1_vsync;
      out_item.sound_byte       <= s1_sample_valid ? rd_data[15:8] : 8'd0;
      out_item.drive_speed_byte <= s1_sample_valid ? rd_data[7:0] : 8'd0;
      out_item.sample_valid     <= s1_sample_valid;
      out_item.line_number      <= s1_line;
      out_item.slot_number      <= s1_slot;
    end
  end

endmodule

// ----- rtl/core/bvtf_checker.sv -----
// port-level checks of the bitmap video timing and fetch core, with its bind
module bvtf_checker
  import bvtf_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result item changed");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result item present after reset");

  // pixel word is zero off the active area
  a_pixel_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.pixel_valid |-> out_item.pixel_word == 16'd0)
    else $error("pixel word set on a non-pixel slot");

  // sound bytes are zero off the last slot
  a_sound_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.sample_valid
      |-> out_item.sound_byte == 8'd0 && out_item.drive_speed_byte == 8'd0)
    else $error("sound bytes set off the last slot");

  // pixel slots carry the pixel level and never a sound sample
  a_pixel_level: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.pixel_valid
      |-> out_item.beam_level == LEVEL_PIXELS && !out_item.sample_valid)
    else $error("pixel slot with wrong level or sound sample");

endmodule

bind bitmap_video_timing_fetch_core bvtf_checker u_bvtf_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
